// ===== hw/rtl/lbc_pkg.sv =====
// lbc_pkg: shared types, constants and helpers of the LRU block buffer cache.
// Used by lru_block_buffer_cache_unit. No dependencies.
`timescale 1ns / 1ps

package lbc_pkg;

	localparam int NUM_BUFFERS_DEF = 32;

	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int CNT_W   = 8;
	localparam int TICK_W  = 32;
	localparam int HDL_W   = 5;
	localparam int CMD_W   = 2;
	localparam int IN_W    = 80;
	localparam int OUT_W   = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ    = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_NO_FREE = 1'b1
	} status_t;

	// one buffer descriptor as held in the table RAM
	typedef struct packed {
		logic              valid;
		logic [TICK_W-1:0] stamp;
		logic [CNT_W-1:0]  count;
		logic [BLK_W-1:0]  blk;
		logic [DEV_W-1:0]  dev;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

endpackage

// ===== hw/rtl/lbc_ram.sv =====
// lbc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/lru_block_buffer_cache_unit.sv =====
// Buffer descriptor table of an LRU disk-block cache, held in one RAM.
// Depends on lbc_pkg and lbc_ram.
`timescale 1ns / 1ps

// After reset the table is cleared one entry a cycle, while s_axis_tready stays
// low. Then one transaction is handled at a time. A read walks the whole table
// through the single RAM read port, one entry a cycle, looking for the lowest
// matching tag and the oldest unreferenced entry, then writes the chosen entry
// back; with no free entry nothing is written. A read passes through the scan,
// drain and write-back states and then returns to idle. Release, pin and unpin
// do one read-modify-write: the entry is read in the accept cycle and, if the
// index is in range, written back in the RMW state, where the result is
// registered. The result sits in an output register, so a new transaction is
// taken while it waits; a finished transaction holds until that register is free.

module lru_block_buffer_cache_unit #(
	parameter int NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// command[1:0], device_id[9:2], block_number[41:10], entry_index[46:42],
	// current_tick[78:47], zero pad[79]
	input  logic [lbc_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// result_entry[4:0], was_hit[5], need_disk_read[6], status[7]
	output logic [lbc_pkg::OUT_W-1:0] m_axis_tdata
);

	import lbc_pkg::*;

	localparam int IW = $clog2(NUM_BUFFERS);
	localparam int XW = IW + HDL_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);
	localparam logic [XW-1:0] NB_X = XW'(NUM_BUFFERS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WB,
		S_RMW
	} state_t;

	state_t state_q;

	// input fields
	cmd_t              in_cmd;
	logic [DEV_W-1:0]  in_dev;
	logic [BLK_W-1:0]  in_blk;
	logic [HDL_W-1:0]  in_idx;
	logic [TICK_W-1:0] in_tick;

	assign in_cmd  = cmd_t'(s_axis_tdata[1:0]);
	assign in_dev  = s_axis_tdata[9:2];
	assign in_blk  = s_axis_tdata[41:10];
	assign in_idx  = s_axis_tdata[46:42];
	assign in_tick = s_axis_tdata[78:47];

	cmd_t              cmd_q;
	logic [DEV_W-1:0]  dev_q;
	logic [BLK_W-1:0]  blk_q;
	logic [HDL_W-1:0]  idx_q;
	logic [TICK_W-1:0] tick_q;

	logic [IW-1:0]     clr_q;
	logic [IW-1:0]     scan_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;

	// scan results
	logic              hit_q;
	logic [IW-1:0]     sel_q;
	logic [CNT_W-1:0]  hcnt_q;
	logic              hvalid_q;
	logic              found_q;
	logic [TICK_W-1:0] best_q;
	logic [IW-1:0]     vic_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              accept;
	logic              out_free;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	entry_t            rd_entry;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	entry_t            wr_entry;
	logic              res_take;
	logic [OUT_W-1:0]  res_data;

	logic [XW-1:0]     in_idx_x;
	logic [XW-1:0]     idx_x_q;
	logic              in_range;
	logic [XW-1:0]     sel_x;
	logic [XW-1:0]     vic_x;
	logic              tag_match;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign in_idx_x = {{IW{1'b0}}, in_idx};
	assign idx_x_q  = {{IW{1'b0}}, idx_q};
	assign in_range = (idx_x_q < NB_X);
	assign sel_x    = {{HDL_W{1'b0}}, sel_q};
	assign vic_x    = {{HDL_W{1'b0}}, vic_q};

	assign rd_entry  = entry_t'(rd_data);
	assign tag_match = (rd_entry.dev == dev_q) && (rd_entry.blk == blk_q);

	// handle read is issued in the accept cycle, scan reads from the counter
	assign rd_en   = accept || (state_q == S_SCAN);
	assign rd_addr = (state_q == S_SCAN) ? scan_q : in_idx_x[IW-1:0];

	lbc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_BUFFERS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = clr_q;
		wr_entry = '0;
		res_take = 1'b0;
		res_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_WB: begin
				res_take = out_free;
				if (hit_q) begin
					wr_en          = out_free;
					wr_addr        = sel_q;
					wr_entry.valid = 1'b1;
					wr_entry.stamp = tick_q;
					wr_entry.count = cnt_inc(hcnt_q);
					wr_entry.blk   = blk_q;
					wr_entry.dev   = dev_q;
					res_data       = {ST_OK, !hvalid_q, 1'b1, sel_x[HDL_W-1:0]};
				end else if (found_q) begin
					// retagged victim: written valid with the new tag, count one and the current tick; the result flags a disk read
					wr_en          = out_free;
					wr_addr        = vic_q;
					wr_entry.valid = 1'b1;
					wr_entry.stamp = tick_q;
					wr_entry.count = CNT_W'(1);
					wr_entry.blk   = blk_q;
					wr_entry.dev   = dev_q;
					res_data       = {ST_OK, 1'b1, 1'b0, vic_x[HDL_W-1:0]};
				end else begin
					res_data = {ST_NO_FREE, 1'b0, 1'b0, {HDL_W{1'b0}}};
				end
			end
			S_RMW: begin
				res_take = out_free;
				res_data = {ST_OK, 1'b0, 1'b0, idx_q};
				wr_en    = out_free && in_range;
				wr_addr  = idx_x_q[IW-1:0];
				wr_entry = rd_entry;
				case (cmd_q)
					CMD_RELEASE: begin
						wr_entry.count = cnt_dec(rd_entry.count);
						wr_entry.stamp = tick_q;
					end
					CMD_PIN:   wr_entry.count = cnt_inc(rd_entry.count);
					CMD_UNPIN: wr_entry.count = cnt_dec(rd_entry.count);
					default:   wr_en = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			idx_s1 <= scan_q;
			if (res_take) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res_data;
				state_q     <= S_IDLE;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// fold each returned entry into the match and victim search
			if (vld_s1) begin
				if (!hit_q && tag_match) begin
					hit_q    <= 1'b1;
					sel_q    <= idx_s1;
					hcnt_q   <= rd_entry.count;
					hvalid_q <= rd_entry.valid;
				end
				if (rd_entry.count == '0 && (!found_q || rd_entry.stamp < best_q)) begin
					found_q <= 1'b1;
					best_q  <= rd_entry.stamp;
					vic_q   <= idx_s1;
				end
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= in_cmd;
						dev_q   <= in_dev;
						blk_q   <= in_blk;
						idx_q   <= in_idx;
						tick_q  <= in_tick;
						hit_q   <= 1'b0;
						found_q <= 1'b0;
						scan_q  <= '0;
						state_q <= (in_cmd == CMD_READ) ? S_SCAN : S_RMW;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_WB;
				S_WB:    ;
				S_RMW:   ;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !s_axis_tready)
		else $error("transaction accepted during table clear");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second transaction accepted while one is in progress");

	a_no_free_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res_data[7]) |-> (!wr_en && res_data[6:0] == '0))
		else $error("no-free result carries data or writes the table");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({{HDL_W{1'b0}}, wr_addr} < NB_X))
		else $error("table write beyond last entry");
`endif

endmodule
